@@ rtl/object_file_section_loader_top_macros.svh @@
// Assertion macros shared by the checker.
`ifndef OBJECT_FILE_SECTION_LOADER_TOP_MACROS_SVH
`define OBJECT_FILE_SECTION_LOADER_TOP_MACROS_SVH

// Next-cycle implication, ignored while reset is high.
`define OFSL_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("ofsl assertion failed");

// Next-cycle implication that also holds through reset.
`define OFSL_ASSERT_NEXT_ALWAYS(label, clk, lhs, rhs) \
   label: assert property (@(posedge clk) (lhs) |=> (rhs)) \
      else $error("ofsl assertion failed");

`endif

@@ rtl/ofsl_pkg.sv @@
`timescale 1ns / 1ps
package ofsl_pkg;

   typedef enum logic [3:0] {
      PH_HDR_HI,
      PH_HDR_LO,
      PH_ADR_HI,
      PH_ADR_LO,
      PH_CNT_HI,
      PH_CNT_LO,
      PH_PAY_HI,
      PH_PAY_LO,
      PH_SKIP
   } phase_type;

   typedef enum logic [1:0] {
      HDR_CODE   = 2'd0,
      HDR_DATA   = 2'd1,
      HDR_SYMBOL = 2'd2
   } header_type;

   typedef enum logic {
      CMD_SET_ADDR = 1'b0,
      CMD_WRITE    = 1'b1
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type  op;
      logic [15:0] data;
      logic        kind;
   } cmd_type;

   localparam logic [7:0] CODE_HI = 8'hCA;
   localparam logic [7:0] CODE_LO = 8'hDE;
   localparam logic [7:0] DATA_HI = 8'hDA;
   localparam logic [7:0] DATA_LO = 8'hDA;
   localparam logic [7:0] SYM_HI  = 8'hC3;
   localparam logic [7:0] SYM_LO  = 8'hB7;

   localparam int CMD_QUEUE_DEPTH = 4;
   localparam int CMD_PTR_W       = $clog2(CMD_QUEUE_DEPTH);

endpackage

@@ rtl/ofsl_front.sv @@
`timescale 1ns / 1ps
module ofsl_front
   import ofsl_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       byte_valid,
   input  logic [7:0] byte_in,
   output logic       cmd_push,
   output cmd_type    cmd_data
);

   phase_type   phase_ff, phase_in;
   logic [7:0]  held_ff, held_in;
   header_type  hdr_ff, hdr_in;
   logic [15:0] count_ff, count_in;
   logic [15:0] word;
   logic [15:0] count_dec;

   assign word      = {held_ff, byte_in};
   assign count_dec = count_ff - 16'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HDR_HI;
         held_ff  <= '0;
         hdr_ff   <= HDR_CODE;
         count_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         held_ff  <= held_in;
         hdr_ff   <= hdr_in;
         count_ff <= count_in;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      held_in  = held_ff;
      hdr_in   = hdr_ff;
      count_in = count_ff;
      cmd_push = 1'b0;
      cmd_data = '{op: CMD_SET_ADDR, data: word, kind: hdr_ff[0]};
      if (byte_valid) begin
         unique case (phase_ff)
            PH_HDR_LO: begin
               if (held_ff == CODE_HI && byte_in == CODE_LO) begin
                  hdr_in   = HDR_CODE;
                  phase_in = PH_ADR_HI;
               end else if (held_ff == DATA_HI && byte_in == DATA_LO) begin
                  hdr_in   = HDR_DATA;
                  phase_in = PH_ADR_HI;
               end else if (held_ff == SYM_HI && byte_in == SYM_LO) begin
                  hdr_in   = HDR_SYMBOL;
                  phase_in = PH_ADR_HI;
               end else begin
                  phase_in = PH_HDR_HI;
               end
            end
            PH_ADR_HI: begin
               held_in  = byte_in;
               phase_in = PH_ADR_LO;
            end
            PH_ADR_LO: begin
               cmd_push = 1'b1;
               phase_in = PH_CNT_HI;
            end
            PH_CNT_HI: begin
               held_in  = byte_in;
               phase_in = PH_CNT_LO;
            end
            PH_CNT_LO: begin
               count_in = word;
               if (word == 16'd0) begin
                  phase_in = PH_HDR_HI;
               end else if (hdr_ff == HDR_SYMBOL) begin
                  phase_in = PH_SKIP;
               end else begin
                  phase_in = PH_PAY_HI;
               end
            end
            PH_PAY_HI: begin
               held_in  = byte_in;
               phase_in = PH_PAY_LO;
            end
            PH_PAY_LO: begin
               cmd_push    = 1'b1;
               cmd_data.op = CMD_WRITE;
               count_in    = count_dec;
               phase_in    = (count_dec == 16'd0) ? PH_HDR_HI : PH_PAY_HI;
            end
            PH_SKIP: begin
               count_in = count_dec;
               if (count_dec == 16'd0) begin
                  phase_in = PH_HDR_HI;
               end
            end
            default: begin
               held_in  = byte_in;
               phase_in = PH_HDR_LO;
            end
         endcase
      end
   end

endmodule

@@ rtl/ofsl_cmd_queue.sv @@
`timescale 1ns / 1ps
module ofsl_cmd_queue
   import ofsl_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   input  logic    pop,
   output cmd_type pop_data,
   output logic    full,
   output logic    empty
);

   cmd_type              entry_ff [CMD_QUEUE_DEPTH];
   logic [CMD_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CMD_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CMD_PTR_W:0]   count_ff, count_in;
   logic                 do_push, do_pop;

   assign full     = count_ff == (CMD_PTR_W + 1)'(CMD_QUEUE_DEPTH);
   assign empty    = count_ff == '0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ rtl/ofsl_back.sv @@
`timescale 1ns / 1ps
module ofsl_back
   import ofsl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        cmd_empty,
   input  cmd_type     cmd_data,
   output logic        cmd_pop,
   output logic        out_valid,
   input  logic        out_take,
   output logic [15:0] out_address,
   output logic [15:0] out_value,
   output logic        out_kind
);

   logic [15:0] addr_ff, addr_in;
   logic        kind_ff, kind_in;
   logic        valid_ff, valid_in;
   logic [15:0] oaddr_ff, oaddr_in;
   logic [15:0] oval_ff, oval_in;
   logic        okind_ff, okind_in;

   assign cmd_pop     = !cmd_empty && (!valid_ff || out_take);
   assign out_valid   = valid_ff;
   assign out_address = oaddr_ff;
   assign out_value   = oval_ff;
   assign out_kind    = okind_ff;

   always_comb begin
      addr_in  = addr_ff;
      kind_in  = kind_ff;
      valid_in = valid_ff && !out_take;
      oaddr_in = oaddr_ff;
      oval_in  = oval_ff;
      okind_in = okind_ff;
      if (cmd_pop) begin
         unique case (cmd_data.op)
            CMD_SET_ADDR: begin
               addr_in = cmd_data.data;
               kind_in = cmd_data.kind;
            end
            CMD_WRITE: begin
               valid_in = 1'b1;
               oaddr_in = addr_ff;
               oval_in  = cmd_data.data;
               okind_in = kind_ff;
               addr_in  = addr_ff + 16'd1;
            end
            default: begin
               addr_in = addr_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff  <= '0;
         kind_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         addr_ff  <= addr_in;
         kind_ff  <= kind_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      oaddr_ff <= oaddr_in;
      oval_ff  <= oval_in;
      okind_ff <= okind_in;
   end

endmodule

@@ rtl/object_file_section_loader_top.sv @@
`timescale 1ns / 1ps
// channel    | direction | handshake        | payload
// req_       | in        | req_push / full  | req_byte_in[7:0]
// rsp_       | out       | rsp_pop / empty  | rsp_write_address, rsp_write_value,
//            |           |                  | rsp_section_kind
//
// One byte is taken each cycle while req_full is low.
// A payload word's write reaches the result ports after the edge that takes its
// low byte, through a 4-entry command queue and then the result register.
// Synchronous reset: decoder hunts for a header, queue and result empty.
// req_full rises only when the queue is full, i.e. results are left waiting.
module object_file_section_loader_top
   import ofsl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_byte_in,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [15:0] rsp_write_address,
   output logic [15:0] rsp_write_value,
   output logic        rsp_section_kind
);

   logic    byte_valid;
   logic    cmd_push, cmd_pop, cmd_empty;
   cmd_type cmd_in, cmd_out;
   logic    out_valid;

   assign byte_valid = req_push && !req_full;
   assign rsp_empty  = !out_valid;

   ofsl_front u_front (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (byte_valid),
      .byte_in    (req_byte_in),
      .cmd_push   (cmd_push),
      .cmd_data   (cmd_in)
   );

   ofsl_cmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in),
      .pop       (cmd_pop),
      .pop_data  (cmd_out),
      .full      (req_full),
      .empty     (cmd_empty)
   );

   ofsl_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_empty   (cmd_empty),
      .cmd_data    (cmd_out),
      .cmd_pop     (cmd_pop),
      .out_valid   (out_valid),
      .out_take    (rsp_pop),
      .out_address (rsp_write_address),
      .out_value   (rsp_write_value),
      .out_kind    (rsp_section_kind)
   );

endmodule

@@ rtl/ofsl_checker.sv @@
`timescale 1ns / 1ps
`include "object_file_section_loader_top_macros.svh"
module ofsl_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_push,
   input logic        req_full,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic [15:0] rsp_write_address,
   input logic [15:0] rsp_write_value,
   input logic        rsp_section_kind
);

   logic        rsp_wait;
   logic [32:0] rsp_bus;
   assign rsp_wait = !rsp_empty && !rsp_pop;
   assign rsp_bus  = {rsp_write_address, rsp_write_value, rsp_section_kind};

   `OFSL_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, rsp_empty)
   `OFSL_ASSERT_NEXT_ALWAYS(a_reset_not_full, clock, reset, !req_full)
   // a waiting result transaction holds until taken
   `OFSL_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_wait, !rsp_empty && $stable(rsp_bus))

endmodule

bind object_file_section_loader_top ofsl_checker u_checker (.*);
